// ===== hdl/spf_pkg.sv =====
// Shared package for the smallest-prime-factor sieve.
// Holds sizes, the opcode type, the mod-30 wheel gap table and the
// command/status structs between controller and datapath. No dependencies.
package spf_pkg;

    localparam int unsigned MAX_N    = 65535;
    localparam int          VALUE_W  = 16;
    localparam int          ADDR_W   = 16;
    localparam int          FACTOR_W = 8;
    localparam int          K_W      = ADDR_W + 1;
    localparam int          P_W      = 9;
    localparam int          PP_W     = 2 * P_W;
    localparam int          GAP_W    = 3;
    localparam int          SLOT_W   = 3;

    localparam logic [K_W-1:0]  MAX_N_K  = K_W'(MAX_N);
    localparam logic [PP_W-1:0] MAX_N_PP = PP_W'(MAX_N);
    localparam logic [P_W-1:0]  P_FIRST  = P_W'(7);

    typedef enum logic {
        OP_BUILD = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    // Gaps between successive numbers coprime to 30, starting from 7.
    function automatic logic [GAP_W-1:0] wheel_gap(input logic [SLOT_W-1:0] slot);
        logic [GAP_W-1:0] gap;
        case (slot)
            3'd0:    gap = 3'd4;
            3'd1:    gap = 3'd2;
            3'd2:    gap = 3'd4;
            3'd3:    gap = 3'd2;
            3'd4:    gap = 3'd4;
            3'd5:    gap = 3'd6;
            3'd6:    gap = 3'd2;
            default: gap = 3'd6;
        endcase
        return gap;
    endfunction

    typedef struct packed {
        logic fill_start;
        logic fill_step;
        logic p_square;
        logic p_advance;
        logic k_load;
        logic k_read;
        logic k_mark;
        logic q_read;
        logic out_load_query;
        logic out_load_build;
        logic built;
    } spf_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic pp_over;
        logic p_marked;
        logic k_over;
    } spf_stat_t;

endpackage

// ===== hdl/spf_datapath.sv =====
// Datapath of the smallest-prime-factor sieve: factor memory, fill and
// wheel counters, and the result register. Depends on spf_pkg.
module spf_datapath import spf_pkg::*; (
    input  logic                aclk,
    input  logic [VALUE_W-1:0]  s_value,
    input  spf_cmd_t            cmd,
    output spf_stat_t           stat,
    output logic                m_status,
    output logic [FACTOR_W-1:0] m_smallest_factor,
    output logic                m_is_prime
);

    logic [FACTOR_W-1:0] fac_mem [0:MAX_N];
    logic [FACTOR_W-1:0] rdata_reg;

    logic [K_W-1:0]    n_reg;
    logic [1:0]        mod3_reg;
    logic [2:0]        mod5_reg;
    logic [P_W-1:0]    p_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [PP_W-1:0]   pp_reg;
    logic [K_W-1:0]    k_reg;
    logic              q_ge2_reg;
    logic              q_in_range_reg;

    logic [FACTOR_W-1:0] fill_val;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [FACTOR_W-1:0] wr_data;
    logic                rdata_zero;

    assign rdata_zero = (rdata_reg == '0);

    // Initial entry: 2 beats 3 beats 5, as the smallest factor wins.
    always_comb begin
        if (!n_reg[0] && n_reg >= K_W'(4)) begin
            fill_val = FACTOR_W'(2);
        end else if (mod3_reg == 2'd0 && n_reg >= K_W'(9)) begin
            fill_val = FACTOR_W'(3);
        end else if (mod5_reg == 3'd0 && n_reg >= K_W'(25)) begin
            fill_val = FACTOR_W'(5);
        end else begin
            fill_val = '0;
        end
    end

    always_comb begin
        rd_en   = cmd.q_read | cmd.p_square | cmd.k_read;
        rd_addr = k_reg[ADDR_W-1:0];
        if (cmd.q_read) begin
            rd_addr = s_value;
        end else if (cmd.p_square) begin
            rd_addr = ADDR_W'(p_reg);
        end
        wr_en   = cmd.fill_step | (cmd.k_mark & rdata_zero);
        wr_addr = cmd.fill_step ? n_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
        wr_data = cmd.fill_step ? fill_val : p_reg[FACTOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fac_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= fac_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill_start) begin
            n_reg    <= '0;
            mod3_reg <= '0;
            mod5_reg <= '0;
            p_reg    <= P_FIRST;
            slot_reg <= '0;
        end
        if (cmd.fill_step) begin
            n_reg    <= n_reg + K_W'(1);
            mod3_reg <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            mod5_reg <= (mod5_reg == 3'd4) ? 3'd0 : mod5_reg + 3'd1;
        end
        if (cmd.p_square) begin
            pp_reg <= p_reg * p_reg;
        end
        if (cmd.p_advance) begin
            p_reg    <= p_reg + P_W'(wheel_gap(slot_reg));
            slot_reg <= slot_reg + SLOT_W'(1);
        end
        if (cmd.k_load) begin
            k_reg <= pp_reg[K_W-1:0];
        end
        if (cmd.k_mark) begin
            k_reg <= k_reg + K_W'({p_reg, 1'b0});
        end
        if (cmd.q_read) begin
            q_ge2_reg      <= (s_value >= VALUE_W'(2));
            q_in_range_reg <= ({1'b0, s_value} <= MAX_N_K);
        end
        if (cmd.out_load_query) begin
            m_status          <= ~cmd.built;
            m_smallest_factor <= (cmd.built && q_in_range_reg) ? rdata_reg : '0;
            m_is_prime        <= cmd.built & q_in_range_reg & q_ge2_reg & rdata_zero;
        end else if (cmd.out_load_build) begin
            m_status          <= 1'b0;
            m_smallest_factor <= '0;
            m_is_prime        <= 1'b0;
        end
    end

    assign stat.fill_last = (n_reg == MAX_N_K);
    assign stat.pp_over   = (pp_reg > MAX_N_PP);
    assign stat.p_marked  = ~rdata_zero;
    assign stat.k_over    = (k_reg > MAX_N_K);

endmodule

// ===== hdl/spf_ctrl.sv =====
// Controller of the smallest-prime-factor sieve: handshakes, build
// sequencing and the built flag. Depends on spf_pkg.
module spf_ctrl import spf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_opcode,
    output logic      m_valid,
    input  logic      m_ready,
    input  spf_stat_t stat,
    output spf_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_QUERY = 8'b0000_0010,
        S_FILL  = 8'b0000_0100,
        S_PSQ   = 8'b0000_1000,
        S_PCHK  = 8'b0001_0000,
        S_KRD   = 8'b0010_0000,
        S_KWR   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   built_reg, built_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = ~m_valid_reg | m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        built_next   = built_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.built    = built_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_QUERY: begin
                if (out_free) begin
                    cmd.out_load_query = 1'b1;
                    m_valid_next       = 1'b1;
                    s_ready            = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last) begin
                    state_next = S_PSQ;
                end
            end
            S_PSQ: begin
                cmd.p_square = 1'b1;
                state_next   = S_PCHK;
            end
            S_PCHK: begin
                if (stat.pp_over) begin
                    state_next = S_DONE;
                end else if (stat.p_marked) begin
                    cmd.p_advance = 1'b1;
                    state_next    = S_PSQ;
                end else begin
                    cmd.k_load = 1'b1;
                    state_next = S_KRD;
                end
            end
            S_KRD: begin
                if (stat.k_over) begin
                    cmd.p_advance = 1'b1;
                    state_next    = S_PSQ;
                end else begin
                    cmd.k_read = 1'b1;
                    state_next = S_KWR;
                end
            end
            S_KWR: begin
                cmd.k_mark = 1'b1;
                state_next = S_KRD;
            end
            S_DONE: begin
                built_next = 1'b1;
                if (out_free) begin
                    cmd.out_load_build = 1'b1;
                    m_valid_next       = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (s_valid && s_ready) begin
            if (opcode_t'(s_opcode) == OP_QUERY) begin
                cmd.q_read = 1'b1;
                state_next = S_QUERY;
            end else begin
                cmd.fill_start = 1'b1;
                state_next     = S_FILL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            built_reg   <= built_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/smallest_prime_factor_sieve.sv =====
// Top level of the smallest-prime-factor sieve.
// Instantiates spf_ctrl and spf_datapath; depends on spf_pkg.
//
// The block keeps a 65536 x 8 table holding the smallest prime factor of
// every number 0..MAX_N (0 for primes, 0 and 1). An item with opcode build
// fills the table and returns one result with everything zero; an item with
// opcode query returns the stored factor, a prime flag, and status 1 when no
// build has completed since reset. Queries read one memory word each: the read
// is issued in the cycle the item is accepted, the read data is registered, and
// the result register is loaded in S_QUERY once the output is free, so queries
// stream at one item per cycle while the result side keeps up, and one further
// item is taken while a result waits. A build first sweeps the whole table at
// one entry per cycle, writing the factors 2, 3 and 5 directly, then runs the
// wheel phase: each wheel candidate from 7 up to 257 is read and checked, and
// for each sieving prime every odd multiple from its square is read and marked
// if still zero; input is not accepted meanwhile.
// The table needs no clearing after reset, since the build sweep writes every
// entry and queries before the first build return zero in place of its data.
module smallest_prime_factor_sieve import spf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_status,
    output logic [FACTOR_W-1:0] m_smallest_factor,
    output logic                m_is_prime
);

    spf_cmd_t  cmd;
    spf_stat_t stat;

    // Sequencer: accepts items, walks the build phases, owns the output valid.
    spf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Factor memory, counters and the result register.
    spf_datapath u_dp (
        .aclk              (aclk),
        .s_value           (s_value),
        .cmd               (cmd),
        .stat              (stat),
        .m_status          (m_status),
        .m_smallest_factor (m_smallest_factor),
        .m_is_prime        (m_is_prime)
    );

    // Once a build starts, no item is taken until the sweep is under way.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_start |=> !s_ready)
        else $error("input accepted right after a build started");

    // A not-built answer carries no factor and no prime flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_smallest_factor == '0 && !m_is_prime))
        else $error("not-built result carries data");

    // A prime has no stored factor and is only reported from a built table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_prime) |-> (m_smallest_factor == '0 && !m_status))
        else $error("prime flag with a factor or without a table");

    // A result is loaded only when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load_query || cmd.out_load_build) |-> (!m_valid || m_ready))
        else $error("result overwritten before it was taken");

endmodule
